// ===== hdl/ild_pkg.sv =====
`timescale 1ns / 1ps

package ild_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int POS_W        = 8;
	localparam int DATA_W       = 32;

	typedef enum logic [1:0] {
		ST_ELEMENT = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef struct packed {
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] element;
		logic                     direction;
		status_t                  status;
		logic                     last;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_WRITE,
		S_PRIME,
		S_DUMP,
		S_STATUS
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    latch;
		logic    we;
		logic    wr_from_rd;
		logic    count_inc;
		logic    out_load;
		status_t out_kind;
		logic    out_dir;
		logic    out_last;
	} ild_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pos_gt_count;
		logic full;
		logic out_free;
	} ild_sts_t;

endpackage

// ===== hdl/ild_ctrl.sv =====
`timescale 1ns / 1ps

module ild_ctrl #(
	parameter int CAPACITY = ild_pkg::CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY),
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ild_pkg::ild_sts_t sts,
	input  logic [CW-1:0]     count,
	input  logic [AW-1:0]     pos_lo,
	output ild_pkg::ild_cmd_t cmd,
	output logic [AW-1:0]     wr_addr,
	output logic [AW-1:0]     rd_addr
);

	ild_pkg::state_t state_q, state_d;
	logic [AW-1:0]   idx_q, idx_d;
	logic            dir_q, dir_d;
	logic            kind_full_q, kind_full_d;
	logic [AW-1:0]   last_idx;
	logic [AW-1:0]   idx_m1;

	assign last_idx = AW'(count - CW'(1));
	assign idx_m1   = idx_q - AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ild_pkg::S_IDLE;
			idx_q       <= '0;
			dir_q       <= 1'b0;
			kind_full_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			dir_q       <= dir_d;
			kind_full_q <= kind_full_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		dir_d       = dir_q;
		kind_full_d = kind_full_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.out_kind = ild_pkg::ST_ELEMENT;
		wr_addr     = idx_q;
		rd_addr     = idx_q;

		unique case (state_q)
			ild_pkg::S_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
				if (in_valid) begin
					state_d = ild_pkg::S_CHECK;
				end
			end
			ild_pkg::S_CHECK: begin
				if (sts.pos_gt_count) begin
					kind_full_d = 1'b0;
					state_d     = ild_pkg::S_STATUS;
				end else if (sts.full) begin
					kind_full_d = 1'b1;
					state_d     = ild_pkg::S_STATUS;
				end else if (AW'(count) == pos_lo) begin
					state_d = ild_pkg::S_WRITE;
				end else begin
					idx_d   = AW'(count);
					state_d = ild_pkg::S_SHIFT_RD;
				end
			end
			ild_pkg::S_SHIFT_RD: begin
				rd_addr = idx_m1;
				state_d = ild_pkg::S_SHIFT_WR;
			end
			ild_pkg::S_SHIFT_WR: begin
				// move entry idx-1 back to idx
				cmd.we         = 1'b1;
				cmd.wr_from_rd = 1'b1;
				wr_addr        = idx_q;
				idx_d          = idx_m1;
				state_d = (idx_m1 == pos_lo) ? ild_pkg::S_WRITE : ild_pkg::S_SHIFT_RD;
			end
			ild_pkg::S_WRITE: begin
				cmd.we        = 1'b1;
				cmd.count_inc = 1'b1;
				wr_addr       = pos_lo;
				idx_d         = '0;
				dir_d         = 1'b0;
				state_d       = ild_pkg::S_PRIME;
			end
			ild_pkg::S_PRIME: begin
				// read of the front entry lands in the read register
				rd_addr = idx_q;
				state_d = ild_pkg::S_DUMP;
			end
			ild_pkg::S_DUMP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_dir  = dir_q;
					cmd.out_last = dir_q && (idx_q == '0);
					if (cmd.out_last) begin
						state_d = ild_pkg::S_IDLE;
					end else if (!dir_q) begin
						if (idx_q == last_idx) begin
							dir_d = 1'b1;
						end else begin
							idx_d = idx_q + AW'(1);
						end
					end else begin
						idx_d = idx_m1;
					end
					// read ahead so the next item is already in the read register for the next load
					rd_addr = idx_d;
				end
			end
			ild_pkg::S_STATUS: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					cmd.out_kind = kind_full_q ? ild_pkg::ST_FULL : ild_pkg::ST_INVALID;
					state_d      = ild_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ild_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/ild_dp.sv =====
`timescale 1ns / 1ps

module ild_dp #(
	parameter int CAPACITY = ild_pkg::CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY),
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ild_pkg::in_item_t  in_item,
	input  ild_pkg::ild_cmd_t  cmd,
	input  logic [AW-1:0]      wr_addr,
	input  logic [AW-1:0]      rd_addr,
	output ild_pkg::ild_sts_t  sts,
	output logic [CW-1:0]      count,
	output logic [AW-1:0]      pos_lo,
	output logic               out_valid,
	input  logic               out_ready,
	output ild_pkg::out_item_t out_item
);

	logic signed [ild_pkg::DATA_W-1:0] mem [CAPACITY];
	logic signed [ild_pkg::DATA_W-1:0] rdata_q;
	logic signed [ild_pkg::DATA_W-1:0] wdata;
	logic [ild_pkg::POS_W-1:0]         pos_q;
	logic signed [ild_pkg::DATA_W-1:0] val_q;
	logic [CW-1:0]                     count_q;
	logic                              out_valid_q;
	ild_pkg::out_item_t                out_q;

	assign wdata = cmd.wr_from_rd ? rdata_q : val_q;

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[wr_addr] <= wdata;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			pos_q <= in_item.position;
			val_q <= in_item.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.count_inc) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.element   <= (cmd.out_kind == ild_pkg::ST_ELEMENT) ? rdata_q : '0;
			out_q.direction <= cmd.out_dir;
			out_q.status    <= cmd.out_kind;
			out_q.last      <= cmd.out_last;
		end
	end

	assign sts.pos_gt_count = pos_q > ild_pkg::POS_W'(count_q);
	assign sts.full         = count_q == CW'(CAPACITY);
	assign sts.out_free     = !out_valid_q || out_ready;
	assign count            = count_q;
	assign pos_lo           = pos_q[AW-1:0];
	assign out_valid        = out_valid_q;
	assign out_item         = out_q;

endmodule

// ===== hdl/indexed_list_insert_dump.sv =====
`timescale 1ns / 1ps

// Ordered store of up to CAPACITY signed values with insert-at-position and a
// two-way dump. An item with a position beyond the count, or one arriving with
// the store full, gives one status result, loaded into the output register
// once it is free. A valid insert at position p with c entries already stored
// moves the tail back one place through the store, with one read state and
// one write state per entry, then writes the value and streams 2*(c+1)
// results at one per cycle while the output is not stalled. One item is worked
// on at a time; the next is taken once the previous last result is in the
// output register. The store has no reset and needs no clearing pass, only
// the count is cleared.
module indexed_list_insert_dump #(
	parameter int CAPACITY = ild_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ild_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output ild_pkg::out_item_t out_item
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	ild_pkg::ild_cmd_t cmd;
	ild_pkg::ild_sts_t sts;
	logic [CW-1:0]     count;
	logic [AW-1:0]     pos_lo;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;

	ild_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.count    (count),
		.pos_lo   (pos_lo),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr)
	);

	ild_dp #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.sts       (sts),
		.count     (count),
		.pos_lo    (pos_lo),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(CAPACITY))
		else $error("count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count != $past(count) |-> count == $past(count) + CW'(1))
		else $error("count moved by other than one");

	a_status_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ild_pkg::ST_ELEMENT |->
			out_item.last && out_item.element == '0 && !out_item.direction)
		else $error("malformed status item");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while busy");

endmodule
